// ===== design/bsq_pkg.sv =====
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared widths, constants, register map and types of the battery stability
// qualifier.
// ----------------------------------------------------------------------------
package bsq_pkg;

    // burst layout: HALF_BURST must stay a power of two (mean is a shift)
    localparam int HALF_BURST = 8;
    localparam int BURST_LEN  = 2 * HALF_BURST;
    localparam int PHASE_W    = $clog2(BURST_LEN);

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = SAMPLE_W + $clog2(HALF_BURST);
    localparam int CELL_W     = 16;
    localparam int DIV_W      = 7;
    localparam int PROD_W     = SAMPLE_W + DIV_W;

    // floor(x / 10) as (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2**22
    localparam int DIV10_SHIFT = 23;
    localparam int RECIP_W     = 20;
    localparam int RPROD_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV10_MUL = RECIP_W'((2 ** DIV10_SHIFT + 9) / 10);

    // sample maximum
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SPREAD_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_CELL     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIVIDER      = 2'd2;

    localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT_RST = 12'd40;
    localparam logic [CELL_W-1:0]   MIN_CELL_RST     = 16'd2500;
    localparam logic [DIV_W-1:0]    DIVIDER_RST      = 7'd49;

    typedef struct packed {
        logic [SAMPLE_W-1:0] spread_limit_mv;
        logic [CELL_W-1:0]   min_cell_mv;
        logic [DIV_W-1:0]    divider_tenths;
    } t_cfg;

    // closing figures of one burst
    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_mv;
        logic [SAMPLE_W-1:0] spread_mv;
    } t_burst_res;

endpackage

// ===== design/bsq_burst_acc.sv =====
// ----------------------------------------------------------------------------
// bsq_burst_acc
// Burst bookkeeping: min/max over the first half, sum over the second half,
// closing figures on the last beat of the burst.
// ----------------------------------------------------------------------------
module bsq_burst_acc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_beat,
    input  logic [bsq_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                           o_last,
    output logic                           o_done,
    output bsq_pkg::t_burst_res            o_res
);

    localparam logic [bsq_pkg::PHASE_W-1:0] HALF_PHASE =
        bsq_pkg::PHASE_W'(bsq_pkg::HALF_BURST);
    localparam logic [bsq_pkg::PHASE_W-1:0] LAST_PHASE =
        bsq_pkg::PHASE_W'(bsq_pkg::BURST_LEN - 1);

    logic [bsq_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic [bsq_pkg::SAMPLE_W-1:0] r_lo, n_lo;
    logic [bsq_pkg::SAMPLE_W-1:0] r_hi, n_hi;
    logic [bsq_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [bsq_pkg::SUM_W-1:0]    w_sum_tot;
    logic [bsq_pkg::SUM_W-1:0]    w_mean_full;

    assign o_last      = (r_phase == LAST_PHASE);
    assign o_done      = i_beat && o_last;
    assign w_sum_tot   = r_sum + bsq_pkg::SUM_W'(i_sample);
    assign w_mean_full = w_sum_tot / bsq_pkg::SUM_W'(bsq_pkg::HALF_BURST);

    always_comb begin
        o_res.mean_mv   = w_mean_full[bsq_pkg::SAMPLE_W-1:0];
        o_res.spread_mv = (r_hi >= r_lo) ? (r_hi - r_lo) : '0;
    end

    always_comb begin
        n_phase = r_phase;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_sum   = r_sum;
        if (i_beat) begin
            if (r_phase < HALF_PHASE) begin
                if (i_sample < r_lo) begin
                    n_lo = i_sample;
                end
                if (i_sample > r_hi) begin
                    n_hi = i_sample;
                end
                n_phase = r_phase + bsq_pkg::PHASE_W'(1);
            end else if (!o_last) begin
                n_sum   = w_sum_tot;
                n_phase = r_phase + bsq_pkg::PHASE_W'(1);
            end else begin
                // burst closed, back to a fresh burst
                n_phase = '0;
                n_lo    = bsq_pkg::SAMPLE_MAX;
                n_hi    = '0;
                n_sum   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_lo    <= bsq_pkg::SAMPLE_MAX;
            r_hi    <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== design/bsq_result_pipe.sv =====
// ----------------------------------------------------------------------------
// bsq_result_pipe
// Elastic result pipeline: divider ratio multiply, divide by ten through a
// reciprocal, flag evaluation and the output register.
// ----------------------------------------------------------------------------
module bsq_result_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  bsq_pkg::t_burst_res            i_res,
    input  bsq_pkg::t_cfg                  i_cfg,
    output logic                           o_can_load,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bsq_pkg::CELL_W-1:0]     o_cell_mv,
    output logic [bsq_pkg::SAMPLE_W-1:0]   o_spread_mv,
    output logic                           o_is_unstable,
    output logic                           o_battery_valid
);

    // stage 1: burst figures
    logic                           r_v1;
    bsq_pkg::t_burst_res            r_res1;
    // stage 2: mean times ratio
    logic                           r_v2;
    logic [bsq_pkg::PROD_W-1:0]     r_prod2;
    logic [bsq_pkg::SAMPLE_W-1:0]   r_spread2;
    logic                           r_unst2;
    // stage 3: cell millivolts
    logic                           r_v3;
    logic [bsq_pkg::CELL_W-1:0]     r_cell3;
    logic [bsq_pkg::SAMPLE_W-1:0]   r_spread3;
    logic                           r_unst3;
    // output register
    logic                           r_vo;

    logic                           w_load_o, w_load3, w_load2;
    logic                           w_mv1, w_mv2, w_mv3;
    logic [bsq_pkg::RPROD_W-1:0]    w_rprod;

    assign w_load_o   = !r_vo || i_ready;
    assign w_mv3      = r_v3 && w_load_o;
    assign w_load3    = !r_v3 || w_mv3;
    assign w_mv2      = r_v2 && w_load3;
    assign w_load2    = !r_v2 || w_mv2;
    assign w_mv1      = r_v1 && w_load2;
    assign o_can_load = !r_v1 || w_mv1;
    assign o_valid    = r_vo;

    assign w_rprod = bsq_pkg::RPROD_W'(r_prod2) * bsq_pkg::RPROD_W'(bsq_pkg::DIV10_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (o_can_load) begin
                r_v1 <= i_load;
            end
            if (w_load2) begin
                r_v2 <= r_v1;
            end
            if (w_load3) begin
                r_v3 <= r_v2;
            end
            if (w_load_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_res1 <= i_res;
        end
        if (w_mv1) begin
            r_prod2   <= bsq_pkg::PROD_W'(r_res1.mean_mv) *
                         bsq_pkg::PROD_W'(i_cfg.divider_tenths);
            r_spread2 <= r_res1.spread_mv;
            r_unst2   <= (r_res1.spread_mv > i_cfg.spread_limit_mv);
        end
        if (w_mv2) begin
            r_cell3   <= w_rprod[bsq_pkg::DIV10_SHIFT +: bsq_pkg::CELL_W];
            r_spread3 <= r_spread2;
            r_unst3   <= r_unst2;
        end
        if (w_mv3) begin
            o_cell_mv       <= r_cell3;
            o_spread_mv     <= r_spread3;
            o_is_unstable   <= r_unst3;
            o_battery_valid <= !r_unst3 && (r_cell3 >= i_cfg.min_cell_mv);
        end
    end

endmodule

// ===== design/battery_stability_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// battery_stability_qualifier_core
// Qualifies a battery reading from bursts of divider-node samples.
// ----------------------------------------------------------------------------
// throughput: one sample beat per cycle, sustained except for the stall below
// the result beat, once the last sample of a burst is taken, passes through
//   the burst figures, mean times ratio, cell millivolts and output registers
// the sample side only stalls on a burst's last beat while the result
//   pipeline is completely full and the result side is stalled
// reset: synchronous, active low; restarts the burst, empties the result
//   pipeline and loads the register defaults (limit 40, min 2500, ratio 49)
// ----------------------------------------------------------------------------
module battery_stability_qualifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_sample_valid,
    output logic                               o_sample_ready,
    input  logic [bsq_pkg::SAMPLE_W-1:0]       i_sample_mv,
    // result channel
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [bsq_pkg::CELL_W-1:0]         o_cell_mv,
    output logic [bsq_pkg::SAMPLE_W-1:0]       o_spread_mv,
    output logic                               o_is_unstable,
    output logic                               o_battery_valid,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bsq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bsq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bsq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    // configuration registers
    bsq_pkg::t_cfg                  r_cfg;
    logic                           w_wr;
    logic [bsq_pkg::REG_IDX_W-1:0]  w_idx;

    // handshake between burst bookkeeping and result pipeline
    logic                           w_beat;
    logic                           w_last;
    logic                           w_done;
    logic                           w_can_load;
    bsq_pkg::t_burst_res            w_res;

    // ------------------------------------------------------------------
    // apb: zero wait states, word addressed registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[bsq_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spread_limit_mv <= bsq_pkg::SPREAD_LIMIT_RST;
            r_cfg.min_cell_mv     <= bsq_pkg::MIN_CELL_RST;
            r_cfg.divider_tenths  <= bsq_pkg::DIVIDER_RST;
        end else if (w_wr) begin
            case (w_idx)
                bsq_pkg::REG_SPREAD_LIMIT: begin
                    r_cfg.spread_limit_mv <= pwdata[bsq_pkg::SAMPLE_W-1:0];
                end
                bsq_pkg::REG_MIN_CELL: begin
                    r_cfg.min_cell_mv <= pwdata[bsq_pkg::CELL_W-1:0];
                end
                bsq_pkg::REG_DIVIDER: begin
                    r_cfg.divider_tenths <= pwdata[bsq_pkg::DIV_W-1:0];
                end
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bsq_pkg::REG_SPREAD_LIMIT: prdata = bsq_pkg::APB_DATA_W'(r_cfg.spread_limit_mv);
            bsq_pkg::REG_MIN_CELL:     prdata = bsq_pkg::APB_DATA_W'(r_cfg.min_cell_mv);
            bsq_pkg::REG_DIVIDER:      prdata = bsq_pkg::APB_DATA_W'(r_cfg.divider_tenths);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sample side: only the closing beat needs room in the pipeline
    // ------------------------------------------------------------------
    assign o_sample_ready = !w_last || w_can_load;
    assign w_beat         = i_sample_valid && o_sample_ready;

    bsq_burst_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_beat),
        .i_sample (i_sample_mv),
        .o_last   (w_last),
        .o_done   (w_done),
        .o_res    (w_res)
    );

    // ------------------------------------------------------------------
    // result side: ratio multiply, divide by ten, flags, output register
    // ------------------------------------------------------------------
    bsq_result_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_done),
        .i_res           (w_res),
        .i_cfg           (r_cfg),
        .o_can_load      (w_can_load),
        .o_valid         (o_res_valid),
        .i_ready         (i_res_ready),
        .o_cell_mv       (o_cell_mv),
        .o_spread_mv     (o_spread_mv),
        .o_is_unstable   (o_is_unstable),
        .o_battery_valid (o_battery_valid)
    );

endmodule

// ===== design/bsq_checker.sv =====
// ----------------------------------------------------------------------------
// bsq_checker
// Port-level checks of the battery stability qualifier, bound to the top.
// ----------------------------------------------------------------------------
module bsq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_res_valid,
    input logic                               i_res_ready,
    input logic [bsq_pkg::CELL_W-1:0]         o_cell_mv,
    input logic [bsq_pkg::SAMPLE_W-1:0]       o_spread_mv,
    input logic                               o_is_unstable,
    input logic                               o_battery_valid
);

    // a stalled result beat stays
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> $stable(o_cell_mv) && $stable(o_spread_mv)
            && $stable(o_is_unstable) && $stable(o_battery_valid))
        else $error("result payload changed while stalled");

    // an unstable burst never qualifies a battery
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_battery_valid && o_is_unstable))
        else $error("battery marked valid on an unstable burst");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result beat present after reset");

endmodule

bind battery_stability_qualifier_core bsq_checker u_bsq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_cell_mv       (o_cell_mv),
    .o_spread_mv     (o_spread_mv),
    .o_is_unstable   (o_is_unstable),
    .o_battery_valid (o_battery_valid)
);
